// File: src/pwts_pkg.sv
// Shared types, constants and helpers for the procedural wall texel shader.
package pwts_pkg;

  // Texture edge length; must be a power of two between 8 and 1024.
  localparam int TEX_SIZE = 64;
  localparam int TEX_BITS = $clog2(TEX_SIZE);

  localparam logic [7:0] KIND_BRICK = 8'd1;

  // Hash multipliers.
  localparam logic [31:0] HASH_MUL_X    = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y    = 32'd668265263;
  localparam logic [31:0] HASH_MUL_SALT = 32'd2246822519;
  localparam logic [31:0] HASH_MUL_MIX  = 32'd1274126177;

  // Shade factors, unsigned with 16 fraction bits.
  localparam int FACTOR_BITS = 17;
  localparam int SPAN_BITS   = 15;
  localparam logic [FACTOR_BITS-1:0] F_MORTAR      = 17'd39322;
  localparam logic [FACTOR_BITS-1:0] F_BRICK_BASE  = 17'd62259;
  localparam logic [SPAN_BITS-1:0]   F_BRICK_SPAN  = 15'd6554;
  localparam logic [FACTOR_BITS-1:0] F_MARBLE_BASE = 17'd45875;
  localparam logic [SPAN_BITS-1:0]   F_MARBLE_SPAN = 15'd26214;
  // Marble reaches the highest factor.
  localparam logic [FACTOR_BITS-1:0] F_MAX         = F_MARBLE_BASE + FACTOR_BITS'(F_MARBLE_SPAN);

  // Divide by three as multiply by reciprocal; exact for values below 2048.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_PBITS = TEX_BITS + 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic                brick;
    logic                mortar;
    logic [7:0]          kind;
    logic [TEX_BITS-1:0] hx;
    logic [TEX_BITS-1:0] hy;
    rgb_t                color;
  } texel_t;

  typedef struct packed {
    logic        brick;
    logic        mortar;
    logic [31:0] hash;
    rgb_t        color;
  } mix_t;

  function automatic logic [TEX_BITS-1:0] div3(input logic [TEX_BITS-1:0] x);
    logic [DIV3_PBITS-1:0] p;
    p = DIV3_PBITS'(x) * DIV3_PBITS'(DIV3_MUL);
    return TEX_BITS'(p >> DIV3_SHIFT);
  endfunction

  // Truncate coord * TEX_SIZE / 2^16 toward zero and wrap into the texture.
  function automatic logic [TEX_BITS-1:0] wrap_texel(input logic signed [31:0] c);
    logic [32+TEX_BITS-1:0] p;
    logic                   bump;
    p    = {c, {TEX_BITS{1'b0}}};
    bump = c[31] && (p[15:0] != 16'd0);
    return p[16+TEX_BITS-1:16] + TEX_BITS'(bump);
  endfunction

  function automatic logic [7:0] scale_sat(input logic [7:0] c,
                                           input logic [FACTOR_BITS-1:0] f);
    logic [FACTOR_BITS+7:0] p;
    p = (FACTOR_BITS+8)'(c) * (FACTOR_BITS+8)'(f);
    return (p[FACTOR_BITS+7:24] != '0) ? 8'hFF : p[23:16];
  endfunction

endpackage

// File: src/procedural_wall_texel_shader_top.sv
// Top level of the procedural wall texel shader pipeline.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid, in_stall | wall_type, u_coord, v_coord, base_red/green/blue
//   output  | out_valid, out_stall | shade_red, shade_green, shade_blue
//
// Five register stages: texel wrap, hash sum, hash mix, shade factor, color scale.
// One item per clock while out_stall is low.
// Each stage advances when it is empty or the next one moves, so bubbles collapse
// and in_stall rises only when every stage is full and out_stall is high.
// Synchronous reset clears all valid bits; payload registers are not reset.
module procedural_wall_texel_shader_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         wall_type,
  input  logic signed [31:0] u_coord,
  input  logic signed [31:0] v_coord,
  input  logic [7:0]         base_red,
  input  logic [7:0]         base_green,
  input  logic [7:0]         base_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         shade_red,
  output logic [7:0]         shade_green,
  output logic [7:0]         shade_blue
);
  import pwts_pkg::*;

  logic   tex_ready;
  logic   tex_valid;
  texel_t tex_item;
  logic   hash_ready;
  logic   hash_valid;
  mix_t   hash_item;
  logic   shade_ready;

  pwts_texel u_texel (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .wall_type  (wall_type),
    .u_coord    (u_coord),
    .v_coord    (v_coord),
    .base_red   (base_red),
    .base_green (base_green),
    .base_blue  (base_blue),
    .down_ready (hash_ready),
    .up_ready   (tex_ready),
    .out_valid  (tex_valid),
    .out_item   (tex_item)
  );

  pwts_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (tex_valid),
    .in_item    (tex_item),
    .down_ready (shade_ready),
    .up_ready   (hash_ready),
    .out_valid  (hash_valid),
    .out_item   (hash_item)
  );

  pwts_shade u_shade (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (hash_valid),
    .in_item     (hash_item),
    .down_ready  (!out_stall),
    .up_ready    (shade_ready),
    .out_valid   (out_valid),
    .shade_red   (shade_red),
    .shade_green (shade_green),
    .shade_blue  (shade_blue)
  );

  assign in_stall = !tex_ready;

`ifndef SYNTHESIS
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && tex_valid && hash_valid)
    else $error("input stalled while pipeline can advance");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !tex_valid)
    else $error("valid set right after reset");
`endif

endmodule

// File: src/pwts_texel.sv
// Stage 1: texel coordinates, mortar test and hash inputs.
module pwts_texel (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [7:0]             wall_type,
  input  logic signed [31:0]     u_coord,
  input  logic signed [31:0]     v_coord,
  input  logic [7:0]             base_red,
  input  logic [7:0]             base_green,
  input  logic [7:0]             base_blue,
  input  logic                   down_ready,
  output logic                   up_ready,
  output logic                   out_valid,
  output pwts_pkg::texel_t       out_item
);
  import pwts_pkg::*;

  logic [TEX_BITS-1:0] tx;
  logic [TEX_BITS-1:0] ty;
  logic                brick;
  texel_t              item_next;

  always_comb begin
    tx    = wrap_texel(u_coord);
    ty    = wrap_texel(v_coord);
    brick = (wall_type == KIND_BRICK);
    item_next.brick       = brick;
    item_next.mortar      = brick && ((tx[2:0] == 3'd0) || (ty[2:0] == 3'd0));
    item_next.kind        = wall_type;
    item_next.hx          = brick ? tx : div3(tx);
    item_next.hy          = brick ? ty : div3(ty);
    item_next.color.red   = base_red;
    item_next.color.green = base_green;
    item_next.color.blue  = base_blue;
  end

  assign up_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// File: src/pwts_hash.sv
// Stages 2 and 3: multiplicative hash of the texel and wall type.
module pwts_hash (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  pwts_pkg::texel_t in_item,
  input  logic             down_ready,
  output logic             up_ready,
  output logic             out_valid,
  output pwts_pkg::mix_t   out_item
);
  import pwts_pkg::*;

  logic        s2_valid;
  mix_t        s2;
  logic        s2_ready;
  logic        s3_ready;
  mix_t        s2_next;
  mix_t        s3_next;
  logic [31:0] folded;

  always_comb begin
    s2_next.brick  = in_item.brick;
    s2_next.mortar = in_item.mortar;
    s2_next.color  = in_item.color;
    s2_next.hash   = 32'(in_item.hx) * HASH_MUL_X
                   + 32'(in_item.hy) * HASH_MUL_Y
                   + 32'(in_item.kind) * HASH_MUL_SALT;
  end

  always_comb begin
    folded         = s2.hash ^ (s2.hash >> 13);
    s3_next        = s2;
    s3_next.hash   = folded * HASH_MUL_MIX;
  end

  assign s3_ready = !out_valid || down_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign up_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= in_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && in_valid) begin
      s2 <= s2_next;
    end
    if (s3_ready && s2_valid) begin
      out_item <= s3_next;
    end
  end

endmodule

// File: src/pwts_shade.sv
// Stages 4 and 5: shade factor from the hash, then color scaling.
module pwts_shade (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  pwts_pkg::mix_t in_item,
  input  logic           down_ready,
  output logic           up_ready,
  output logic           out_valid,
  output logic [7:0]     shade_red,
  output logic [7:0]     shade_green,
  output logic [7:0]     shade_blue
);
  import pwts_pkg::*;

  localparam int PROD_BITS = 24 + SPAN_BITS;

  logic                   s4_valid;
  logic [FACTOR_BITS-1:0] factor;
  rgb_t                   s4_color;
  logic                   s4_ready;
  logic                   s5_ready;
  logic [23:0]            noise;
  logic [SPAN_BITS-1:0]   span;
  logic [FACTOR_BITS-1:0] base;
  logic [PROD_BITS-1:0]   prod;
  logic [FACTOR_BITS-1:0] factor_next;
  logic [FACTOR_BITS+7:0] red_raw;

  always_comb begin
    noise = in_item.hash[23:0] ^ {8'd0, in_item.hash[31:16]};
    span  = in_item.brick ? F_BRICK_SPAN : F_MARBLE_SPAN;
    base  = in_item.brick ? F_BRICK_BASE : F_MARBLE_BASE;
    prod  = PROD_BITS'(noise) * PROD_BITS'(span);
    factor_next = in_item.mortar ? F_MORTAR
                                 : base + FACTOR_BITS'(prod[PROD_BITS-1:24]);
  end

  assign s5_ready = !out_valid || down_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign up_ready = s4_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid <= in_valid;
      end
      if (s5_ready) begin
        out_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && in_valid) begin
      factor   <= factor_next;
      s4_color <= in_item.color;
    end
    if (s5_ready && s4_valid) begin
      shade_red   <= scale_sat(s4_color.red, factor);
      shade_green <= scale_sat(s4_color.green, factor);
      shade_blue  <= scale_sat(s4_color.blue, factor);
    end
  end

  assign red_raw = (FACTOR_BITS+8)'(s4_color.red) * (FACTOR_BITS+8)'(factor);

`ifndef SYNTHESIS
  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> (factor >= F_MORTAR) && (factor <= F_MAX))
    else $error("shade factor out of range");

  a_sat_only_above_one: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !factor[FACTOR_BITS-1] |-> (red_raw[FACTOR_BITS+7:24] == '0))
    else $error("channel overflow with factor below one");
`endif

endmodule

// File: tb/procedural_wall_texel_shader_top_tb.sv
// Testbench for the procedural wall texel shader: random and directed texels, scoreboard check.
`timescale 1ns / 1ps

module procedural_wall_texel_shader_top_tb;
  import pwts_pkg::*;

  localparam int RANDOM_TEXELS = 1200;
  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 12;

  // Expected shades per accepted texel, computed independently of the RTL.
  class texel_shade_checker;
    rgb_t pending_shades[$];
    int   mismatches;
    int   shades_checked;

    function new();
      mismatches     = 0;
      shades_checked = 0;
    endfunction

    // Scale by TEX_SIZE, truncate toward zero, wrap into [0, TEX_SIZE).
    function int texel_index(logic signed [31:0] c);
      longint p;
      longint q;
      longint r;
      p = longint'(c) * TEX_SIZE;
      if (p < 0) q = -((-p) >>> 16);
      else q = p >>> 16;
      r = q % TEX_SIZE;
      if (r < 0) r += TEX_SIZE;
      return int'(r);
    endfunction

    function bit [23:0] texel_hash(bit [31:0] x, bit [31:0] y, bit [31:0] salt);
      bit [31:0] h;
      h = x * 32'd374761393;
      h = h + y * 32'd668265263;
      h = h + salt * 32'd2246822519;
      h = (h ^ (h >> 13)) * 32'd1274126177;
      h = h ^ (h >> 16);
      return h[23:0];
    endfunction

    function bit [7:0] scaled_channel(bit [7:0] c, bit [16:0] f);
      int unsigned v;
      v = (int'(c) * int'(f)) >> 16;
      return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    function void note_texel(logic [7:0] kind, logic signed [31:0] u, logic signed [31:0] v,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int        tx;
      int        ty;
      bit [23:0] n;
      bit [16:0] f;
      rgb_t      shade;
      tx = texel_index(u);
      ty = texel_index(v);
      if (kind == KIND_BRICK) begin
        if ((tx % 8) == 0 || (ty % 8) == 0) begin
          f = 17'd39322;
        end else begin
          n = texel_hash(tx, ty, kind);
          f = 17'd62259 + 17'((64'(n) * 64'd6554) >> 24);
        end
      end else begin
        n = texel_hash(tx / 3, ty / 3, kind);
        f = 17'd45875 + 17'((64'(n) * 64'd26214) >> 24);
      end
      shade.red   = scaled_channel(r, f);
      shade.green = scaled_channel(g, f);
      shade.blue  = scaled_channel(b, f);
      pending_shades.push_back(shade);
    endfunction

    function void check_shade(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      rgb_t want;
      if (pending_shades.size() == 0) begin
        $error("shade result with no texel outstanding: %0d %0d %0d", r, g, b);
        mismatches++;
        return;
      end
      want = pending_shades.pop_front();
      shades_checked++;
      if (r !== want.red) begin
        $error("shade_red: expected %0d, actual %0d", want.red, r);
        mismatches++;
      end
      if (g !== want.green) begin
        $error("shade_green: expected %0d, actual %0d", want.green, g);
        mismatches++;
      end
      if (b !== want.blue) begin
        $error("shade_blue: expected %0d, actual %0d", want.blue, b);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         wall_type = '0;
  logic signed [31:0] u_coord = '0;
  logic signed [31:0] v_coord = '0;
  logic [7:0]         base_red = '0;
  logic [7:0]         base_green = '0;
  logic [7:0]         base_blue = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         shade_red;
  logic [7:0]         shade_green;
  logic [7:0]         shade_blue;

  texel_shade_checker shade_book;
  bit                 steady_window = 1'b0;
  int                 quiet_cycles = 0;
  int                 directed_count = 0;

  procedural_wall_texel_shader_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .wall_type   (wall_type),
    .u_coord     (u_coord),
    .v_coord     (v_coord),
    .base_red    (base_red),
    .base_green  (base_green),
    .base_blue   (base_blue),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .shade_red   (shade_red),
    .shade_green (shade_green),
    .shade_blue  (shade_blue)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Enter at a falling edge; return at the falling edge after the transfer.
  task automatic send_texel(logic [7:0] kind, logic [31:0] u, logic [31:0] v,
                            logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!steady_window && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    wall_type  <= kind;
    u_coord    <= u;
    v_coord    <= v;
    base_red   <= r;
    base_green <= g;
    base_blue  <= b;
    do @(posedge clk); while (in_stall);
    shade_book.note_texel(kind, u, v, r, g, b);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    case ($urandom_range(0, 3))
      0: c = $urandom;
      1: c = 32'($urandom_range(0, 2 * 65536)) - 32'd65536;
      2: c = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: begin
        // land on exact texel edges, mortar lines among them
        c = 32'($urandom_range(0, 4 * TEX_SIZE)) << (16 - $clog2(TEX_SIZE));
        if ($urandom_range(0, 1)) c = -c;
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= !steady_window && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shade_book.check_shade(shade_red, shade_green, shade_blue);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] kind;
    shade_book = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // mortar corner, brick body, coordinate extremes
    send_texel(KIND_BRICK, 32'd0, 32'd0, 8'hFF, 8'hFF, 8'hFF);
    send_texel(KIND_BRICK, 32'd3 << 10, 32'd5 << 10, 8'hFF, 8'hFF, 8'hFF);
    send_texel(KIND_BRICK, 32'd13 << 10, 32'd27 << 10, 8'd128, 8'd1, 8'd0);
    send_texel(KIND_BRICK, 32'h7FFFFFFF, 32'h80000000, 8'hFF, 8'h00, 8'hAA);
    send_texel(KIND_BRICK, 32'h80000000, 32'h7FFFFFFF, 8'h55, 8'hFF, 8'h00);
    send_texel(KIND_BRICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    // negative coordinates wrap from the far edge
    send_texel(KIND_BRICK, -(32'd9 << 10), 32'd9 << 10, 8'hFF, 8'h80, 8'h01);
    send_texel(KIND_BRICK, -(32'd9 << 10) - 32'd1, -(32'd3 << 10) - 32'd7, 8'hFF, 8'hFF, 8'hFF);
    // mortar line reached with a fractional part
    send_texel(KIND_BRICK, (32'd8 << 10) + 32'd512, 32'd3 << 10, 8'hFF, 8'hFF, 8'hFF);
    send_texel(KIND_BRICK, 32'd5 << 10, (32'd16 << 10) + 32'd1023, 8'hC8, 8'h64, 8'h32);
    // one full texture period wraps to zero
    send_texel(KIND_BRICK, 32'h00010000, 32'h00010000 + (32'd1 << 10), 8'hFF, 8'hFF, 8'hFF);
    // marble salts and regions
    send_texel(8'd0, 32'd0, 32'd0, 8'hFF, 8'hFF, 8'hFF);
    send_texel(8'd0, 32'h80000000, 32'h7FFFFFFF, 8'h00, 8'h00, 8'h00);
    send_texel(8'd2, 32'd7 << 10, 32'd62 << 10, 8'hFF, 8'hFF, 8'hFF);
    send_texel(8'd255, 32'hFFFFFFFF, 32'h00000001, 8'hFF, 8'h7F, 8'h80);
    send_texel(8'd255, -(32'd40 << 10), 32'd63 << 10, 8'hFF, 8'hFF, 8'hFF);
    send_texel(8'hFE, 32'h7FFFFFFF, 32'h7FFFFFFF, 8'h01, 8'hFE, 8'hFF);
    send_texel(8'h80, 32'hFFFF0000, 32'h0000FFFF, 8'hFF, 8'hFF, 8'hFF);
    directed_count = 18;

    for (int i = 0; i < RANDOM_TEXELS; i++) begin
      steady_window = (i >= 500 && i < 800);
      kind = $urandom_range(0, 1) ? KIND_BRICK : 8'($urandom);
      send_texel(kind, pick_coord(), pick_coord(), pick_channel(), pick_channel(),
                 pick_channel());
    end
    steady_window = 1'b0;
    in_valid <= 1'b0;

    while (shade_book.pending_shades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shade_book.pending_shades.size() != 0) begin
      $error("%0d shades never arrived", shade_book.pending_shades.size());
      shade_book.mismatches++;
    end
    $display("covered %0d directed and %0d random texels (brick, mortar, marble, edge coords)",
             directed_count, RANDOM_TEXELS);
    $display("checked %0d shade results, %0d mismatches",
             shade_book.shades_checked, shade_book.mismatches);
    if (shade_book.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
